// ===== src/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctb_pkg
// Types, codes and constants shared by the cascaded timer bank files.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

  localparam logic [2:0] FUNC_ELAPSE     = 3'd0;
  localparam logic [2:0] FUNC_WR_RELOAD  = 3'd1;
  localparam logic [2:0] FUNC_WR_CONTROL = 3'd2;
  localparam logic [2:0] FUNC_RD_COUNT   = 3'd3;
  localparam logic [2:0] FUNC_RD_CONTROL = 3'd4;

  localparam int CTL_ENABLE_BIT  = 7;
  localparam int CTL_IRQ_BIT     = 6;
  localparam int CTL_CASCADE_BIT = 2;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  timer_index;
    logic [15:0] write_value;
    logic [7:0]  elapsed_cycles;
  } req_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [3:0]  irq_raise;
  } rsp_item_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic tick;
    logic advance;
    logic finish;
  } ctb_cmd_t;

  typedef struct packed {
    logic elapse_req;
    logic scan_go;
    logic chain;
    logic tick_last;
    logic src_last;
  } ctb_status_t;

  function automatic logic [3:0] presc_shift(input logic [1:0] sel);
    logic [3:0] sh;
    case (sel)
      2'd0: sh = 4'd0;
      2'd1: sh = 4'd6;
      2'd2: sh = 4'd8;
      default: sh = 4'd10;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

// ===== src/ctb_datapath.sv =====
// ----------------------------------------------------------------------------
// ctb_datapath
// Timer registers, prescaler accumulators, tick walker and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_datapath #(
  parameter int NUM_TIMERS  = 4,
  parameter int MAX_ELAPSED = 255
) (
  input  wire                 clk,
  input  wire                 rst,
  input  ctb_pkg::req_item_t  req,
  input  ctb_pkg::ctb_cmd_t   cmd,
  output ctb_pkg::ctb_status_t status,
  output ctb_pkg::rsp_item_t  rsp
);
  import ctb_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IW-1:0] LAST = IW'(NUM_TIMERS - 1);

  logic [15:0] count   [NUM_TIMERS];
  logic [15:0] reload  [NUM_TIMERS];
  logic [15:0] ctl     [NUM_TIMERS];
  logic [10:0] accum   [NUM_TIMERS];
  logic [7:0]  cyc;
  logic [IW-1:0] src;
  logic [IW-1:0] cur;
  logic [11:0] tick_cnt;
  logic [3:0]  irq;

  logic [IW-1:0] req_idx;
  logic          req_ok;
  logic [7:0]    cyc_sat;
  logic [15:0]   rd_val;
  logic [3:0]    sh;
  logic [11:0]   acc;
  logic [11:0]   ticks;
  logic [10:0]   rem;
  logic          eligible;
  logic [IW-1:0] nxt;
  logic [15:0]   inc;
  logic          ovf;
  logic          chain;
  logic [3:0]    irq_set;

  assign req_idx = req.timer_index[IW-1:0];
  assign req_ok  = {1'b0, req.timer_index} < 3'(NUM_TIMERS);
  assign cyc_sat = ({2'b00, req.elapsed_cycles} > 10'(MAX_ELAPSED)) ?
                   8'(MAX_ELAPSED) : req.elapsed_cycles;

  always_comb begin
    rd_val = 16'd0;
    if (req_ok) begin
      case (req.func)
        FUNC_RD_COUNT:   rd_val = count[req_idx];
        FUNC_RD_CONTROL: rd_val = ctl[req_idx];
        default:         rd_val = 16'd0;
      endcase
    end
  end

  assign sh       = presc_shift(ctl[src][1:0]);
  assign acc      = {1'b0, accum[src]} + {4'd0, cyc};
  assign ticks    = acc >> sh;
  assign rem      = 11'(acc & ((12'd1 << sh) - 12'd1));
  assign eligible = ctl[src][CTL_ENABLE_BIT] &&
                    (src == '0 || !ctl[src][CTL_CASCADE_BIT]);

  assign nxt   = cur + IW'(1);
  assign inc   = count[cur] + 16'd1;
  assign ovf   = (inc == 16'd0);
  assign chain = ovf && (cur != LAST) && ctl[nxt][CTL_CASCADE_BIT] &&
                 ctl[nxt][CTL_ENABLE_BIT];
  assign irq_set = (cmd.tick && ovf && ctl[cur][CTL_IRQ_BIT]) ?
                   (4'd1 << cur) : 4'd0;

  assign status.elapse_req = (req.func == FUNC_ELAPSE);
  assign status.scan_go    = eligible && (ticks != 12'd0);
  assign status.chain      = chain;
  assign status.tick_last  = (tick_cnt == 12'd1);
  assign status.src_last   = (src == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        count[i]  <= 16'd0;
        reload[i] <= 16'd0;
        ctl[i]    <= 16'd0;
        accum[i]  <= 11'd0;
      end
      src      <= '0;
      cur      <= '0;
      tick_cnt <= 12'd0;
      irq      <= 4'd0;
    end else begin
      if (cmd.accept) begin
        cyc <= cyc_sat;
        src <= '0;
        irq <= 4'd0;
        if (req_ok) begin
          case (req.func)
            FUNC_WR_RELOAD: reload[req_idx] <= req.write_value;
            FUNC_WR_CONTROL: begin
              if (!ctl[req_idx][CTL_ENABLE_BIT] && req.write_value[CTL_ENABLE_BIT]) begin
                count[req_idx] <= reload[req_idx];
                accum[req_idx] <= 11'd0;
              end
              ctl[req_idx] <= req.write_value;
            end
            default: ;
          endcase
        end
      end
      if (cmd.scan) begin
        cur <= src;
        if (eligible) begin
          accum[src] <= rem;
          tick_cnt   <= ticks;
        end
      end
      if (cmd.tick) begin
        count[cur] <= ovf ? reload[cur] : inc;
        irq        <= irq | irq_set;
        if (chain) begin
          cur <= nxt;
        end else begin
          cur      <= src;
          tick_cnt <= tick_cnt - 12'd1;
        end
      end
      if (cmd.advance) begin
        src <= src + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !status.elapse_req) begin
      rsp.read_data <= rd_val;
      rsp.irq_raise <= 4'd0;
    end else if (cmd.finish) begin
      rsp.read_data <= 16'd0;
      rsp.irq_raise <= irq | irq_set;
    end
  end

endmodule

`default_nettype wire

// ===== src/ctb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctb_ctrl
// Sequencer for the timer walk and the request/response handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  wire                  rsp_ready,
  input  ctb_pkg::ctb_status_t status,
  output ctb_pkg::ctb_cmd_t    cmd
);
  import ctb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_valid_next;

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.accept = req_valid && req_ready;
    case (state)
      S_IDLE: begin
        if (cmd.accept && status.elapse_req) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_go) begin
          state_next = S_TICK;
        end else if (status.src_last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_TICK: begin
        cmd.tick = 1'b1;
        if (!status.chain && status.tick_last) begin
          if (status.src_last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_SCAN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid && !rsp_ready;
    if (cmd.finish || (cmd.accept && !status.elapse_req)) rsp_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/cascaded_timer_bank_unit.sv =====
// ----------------------------------------------------------------------------
// cascaded_timer_bank_unit
// Bank of cascadable, prescaled 16-bit up-counters with reload and IRQ flags.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_valid / req_ready | req_item_t (func, index, value, cycles)
//  rsp     | out | rsp_valid / rsp_ready | rsp_item_t (read_data, irq_raise)
//
//  Access items (read/write/unknown) answer in the cycle after acceptance;
//  the result is registered. Elapse items walk the timers: the walker scans one
//  timer per cycle between tick runs and applies one counter tick per cycle.
//  A new item is taken once the walk is done and the result slot is free or
//  draining. Synchronous reset clears all timer state to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_timer_bank_unit #(
  parameter int NUM_TIMERS  = 4,
  parameter int MAX_ELAPSED = 255
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  input  ctb_pkg::req_item_t req,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  output ctb_pkg::rsp_item_t rsp
);
  import ctb_pkg::*;

  ctb_cmd_t    cmd;
  ctb_status_t status;

  ctb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ctb_datapath #(
    .NUM_TIMERS  (NUM_TIMERS),
    .MAX_ELAPSED (MAX_ELAPSED)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire

// ===== src/ctb_checker.sv =====
// ----------------------------------------------------------------------------
// ctb_checker
// Port-level checks for the cascaded timer bank, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_checker (
  input wire                clk,
  input wire                rst,
  input wire                req_valid,
  input wire                req_ready,
  input ctb_pkg::req_item_t req,
  input wire                rsp_valid,
  input wire                rsp_ready,
  input ctb_pkg::rsp_item_t rsp
);
  import ctb_pkg::*;

  logic acc_access;
  logic acc_write;

  assign acc_access = req_valid && req_ready && (req.func != FUNC_ELAPSE);
  assign acc_write  = acc_access && (req.func != FUNC_RD_COUNT) &&
                      (req.func != FUNC_RD_CONTROL);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled rsp item changed");

  a_access_done: assert property (@(posedge clk) disable iff (rst)
    acc_access |=> rsp_valid && (rsp.irq_raise == 4'd0))
    else $error("access item result missing or carries irq bits");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    acc_write |=> rsp.read_data == 16'd0)
    else $error("non-read item returned data");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("item taken while result slot is blocked");

endmodule

bind cascaded_timer_bank_unit ctb_checker u_ctb_checker (.*);

`default_nettype wire

// ===== tb/cascaded_timer_bank_unit_tb.sv =====
// ----------------------------------------------------------------------------
// cascaded_timer_bank_unit_tb
// Self-checking bench for the cascaded timer bank. A short directed table
// (reset values, unknown codes, overflow and cascade, prescaler change while
// running, disabled timers, reload of all ones) is followed by random items.
// Results are compared in order against fixed table values or an internal
// model of the four timers; both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cascaded_timer_bank_unit_tb;
  import ctb_pkg::*;

  localparam int NT          = 4;
  localparam int MAX_CYC     = 255;
  localparam int RAND_ITEMS  = 1450;
  // worst walk: leftover accumulator plus a full elapse at divide by 1, per timer
  localparam int WORST_WALK  = 1 + NT + NT * (1023 + MAX_CYC) * 2;
  localparam int CYCLE_LIMIT = (RAND_ITEMS + 100) * (WORST_WALK + 24) * 3;

  typedef struct {
    req_item_t item;
    bit        fixed;
    rsp_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_item_t req_bus;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_item_t rsp_bus;

  logic      cur_fixed;
  rsp_item_t cur_want;
  bit        no_idle;

  logic [15:0] tmr_count  [NT];
  logic [15:0] tmr_reload [NT];
  logic [15:0] tmr_ctl    [NT];
  logic [10:0] tmr_accum  [NT];

  rsp_item_t pending_rsp_q[$];
  stim_row_t dir_tab[$];
  int        mismatches;
  int        rsp_seen;
  int        cycle_cnt;

  cascaded_timer_bank_unit #(
    .NUM_TIMERS (NT),
    .MAX_ELAPSED(MAX_CYC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req_bus),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp_bus)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // one counter tick, carried into cascaded neighbours on overflow
  function automatic void tick_cascade(input int t, inout logic [3:0] irq);
    int j;
    bit done;
    j = t;
    done = 1'b0;
    while (!done) begin
      tmr_count[j] = tmr_count[j] + 16'd1;
      if (tmr_count[j] != 16'd0) begin
        done = 1'b1;
      end else begin
        tmr_count[j] = tmr_reload[j];
        if (tmr_ctl[j][CTL_IRQ_BIT]) irq[j] = 1'b1;
        if (j + 1 >= NT) begin
          done = 1'b1;
        end else if (!tmr_ctl[j+1][CTL_CASCADE_BIT] || !tmr_ctl[j+1][CTL_ENABLE_BIT]) begin
          done = 1'b1;
        end else begin
          j++;
        end
      end
    end
  endfunction

  function automatic rsp_item_t timer_bank_apply(input req_item_t r);
    rsp_item_t  o;
    logic [3:0] irq;
    int         idx;
    int         cyc;
    int         acc;
    int         stepc;
    o   = '0;
    irq = 4'h0;
    idx = r.timer_index;
    cyc = r.elapsed_cycles;
    if (cyc > MAX_CYC) cyc = MAX_CYC;
    case (r.func)
      FUNC_ELAPSE: begin
        for (int i = 0; i < NT; i++) begin
          if (tmr_ctl[i][CTL_ENABLE_BIT] && !(i > 0 && tmr_ctl[i][CTL_CASCADE_BIT])) begin
            case (tmr_ctl[i][1:0])
              2'd0: stepc = 1;
              2'd1: stepc = 64;
              2'd2: stepc = 256;
              default: stepc = 1024;
            endcase
            acc = int'(tmr_accum[i]) + cyc;
            while (acc >= stepc) begin
              acc -= stepc;
              tick_cascade(i, irq);
            end
            tmr_accum[i] = acc[10:0];
          end
        end
      end
      FUNC_WR_RELOAD: begin
        if (idx < NT) tmr_reload[idx] = r.write_value;
      end
      FUNC_WR_CONTROL: begin
        if (idx < NT) begin
          if (!tmr_ctl[idx][CTL_ENABLE_BIT] && r.write_value[CTL_ENABLE_BIT]) begin
            tmr_count[idx] = tmr_reload[idx];
            tmr_accum[idx] = '0;
          end
          tmr_ctl[idx] = r.write_value;
        end
      end
      FUNC_RD_COUNT: begin
        if (idx < NT) o.read_data = tmr_count[idx];
      end
      FUNC_RD_CONTROL: begin
        if (idx < NT) o.read_data = tmr_ctl[idx];
      end
      default: ;
    endcase
    o.irq_raise = irq;
    return o;
  endfunction

  function automatic stim_row_t row(input logic [2:0] f, input logic [1:0] ti,
                                    input logic [15:0] v, input logic [7:0] c,
                                    input bit fx, input logic [15:0] rd,
                                    input logic [3:0] iq);
    stim_row_t s;
    s.item.func           = f;
    s.item.timer_index    = ti;
    s.item.write_value    = v;
    s.item.elapsed_cycles = c;
    s.fixed               = fx;
    s.want.read_data      = rd;
    s.want.irq_raise      = iq;
    return s;
  endfunction

  // expectation at acceptance, comparison at result; push first keeps order
  always @(posedge clk) begin
    rsp_item_t exp_r;
    rsp_item_t pred;
    if (rst) begin
      for (int i = 0; i < NT; i++) begin
        tmr_count[i]  = '0;
        tmr_reload[i] = '0;
        tmr_ctl[i]    = '0;
        tmr_accum[i]  = '0;
      end
    end else begin
      if (req_valid && req_ready) begin
        pred = timer_bank_apply(req_bus);
        pending_rsp_q.push_back(cur_fixed ? cur_want : pred);
      end
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (pending_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d: rd=%h irq=%h", rsp_seen,
                     rsp_bus.read_data, rsp_bus.irq_raise);
        end else begin
          exp_r = pending_rsp_q.pop_front();
          if (rsp_bus.read_data !== exp_r.read_data ||
              rsp_bus.irq_raise !== exp_r.irq_raise) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at result %0d: expected rd=%h irq=%h, got rd=%h irq=%h",
                       rsp_seen, exp_r.read_data, exp_r.irq_raise,
                       rsp_bus.read_data, rsp_bus.irq_raise);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: stall a drawn number of cycles before each item
  initial begin
    int stall;
    rsp_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  task automatic send_item(input req_item_t it, input bit fx, input rsp_item_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_bus   <= it;
    cur_fixed <= fx;
    cur_want  <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  function automatic req_item_t rand_item();
    req_item_t it;
    int        p;
    it.timer_index = 2'($urandom_range(0, 3));
    it.write_value = 16'($urandom);
    p = $urandom_range(0, 9);
    if (p == 0)      it.elapsed_cycles = 8'd0;
    else if (p <= 2) it.elapsed_cycles = 8'd255;
    else             it.elapsed_cycles = 8'($urandom_range(0, 255));
    p = $urandom_range(0, 99);
    if (p < 36) begin
      it.func = FUNC_ELAPSE;
    end else if (p < 52) begin
      it.func = FUNC_WR_RELOAD;
      p = $urandom_range(0, 9);
      if (p < 2)      it.write_value = 16'hFFFF;
      else if (p < 6) it.write_value = {8'hFF, 8'($urandom)};
      else if (p < 7) it.write_value = 16'h0000;
    end else if (p < 72) begin
      it.func = FUNC_WR_CONTROL;
      it.write_value[CTL_ENABLE_BIT] = ($urandom_range(0, 9) < 7);
    end else if (p < 86) begin
      it.func = FUNC_RD_COUNT;
    end else if (p < 95) begin
      it.func = FUNC_RD_CONTROL;
    end else begin
      it.func = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  initial begin
    rsp_item_t none;
    none       = '0;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_bus    = '0;
    cur_fixed  = 1'b0;
    cur_want   = '0;
    no_idle    = 1'b0;
    mismatches = 0;
    rsp_seen   = 0;
    cycle_cnt  = 0;

    dir_tab.push_back(row(FUNC_RD_COUNT,   2'd0, 16'hFFFF, 8'hFF, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_RD_CONTROL, 2'd3, 16'h0000, 8'h00, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(3'd5,            2'd3, 16'hFFFF, 8'hFF, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(3'd7,            2'd2, 16'hFFFF, 8'hFF, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_ELAPSE,     2'd1, 16'hFFFF, 8'hFF, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_WR_RELOAD,  2'd0, 16'hFFFF, 8'h00, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_WR_CONTROL, 2'd0, 16'h00C0, 8'h00, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_RD_CONTROL, 2'd0, 16'h0000, 8'h00, 1, 16'h00C0, 4'h0));
    // all-ones reload: one tick overflows
    dir_tab.push_back(row(FUNC_ELAPSE,     2'd0, 16'h0000, 8'h01, 1, 16'h0000, 4'h1));
    dir_tab.push_back(row(FUNC_WR_RELOAD,  2'd1, 16'hFFFE, 8'h00, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_WR_CONTROL, 2'd1, 16'h00C4, 8'h00, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_ELAPSE,     2'd0, 16'h0000, 8'h03, 0, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_RD_COUNT,   2'd1, 16'h0000, 8'h00, 0, 16'h0000, 4'h0));
    // divider changed while running
    dir_tab.push_back(row(FUNC_WR_CONTROL, 2'd0, 16'h00C3, 8'h00, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_ELAPSE,     2'd0, 16'h0000, 8'hFF, 0, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_ELAPSE,     2'd0, 16'h0000, 8'hFF, 0, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_WR_CONTROL, 2'd0, 16'h00C0, 8'h00, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_ELAPSE,     2'd0, 16'h0000, 8'h10, 0, 16'h0000, 4'h0));
    // disabled timer holds
    dir_tab.push_back(row(FUNC_WR_CONTROL, 2'd2, 16'h0041, 8'h00, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_ELAPSE,     2'd0, 16'h0000, 8'hC8, 0, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_WR_CONTROL, 2'd2, 16'h00C1, 8'h00, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_RD_COUNT,   2'd2, 16'h0000, 8'h00, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_WR_CONTROL, 2'd3, 16'hFFFF, 8'h00, 1, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_ELAPSE,     2'd0, 16'h0000, 8'h00, 0, 16'h0000, 4'h0));
    dir_tab.push_back(row(FUNC_RD_CONTROL, 2'd3, 16'h0000, 8'h00, 1, 16'hFFFF, 4'h0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) send_item(dir_tab[k].item, dir_tab[k].fixed, dir_tab[k].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_item(rand_item(), 1'b0, none);
    end
    req_valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
